// ===== rtl/core/positional_array_list_core_assert.svh =====
// Assertion macros shared by the positional array list RTL.
// Needs nothing else; take it in with an include of the bare file name.
`ifndef POSITIONAL_ARRAY_LIST_CORE_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PAL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("positional_array_list_core: same-cycle property violated");

// Consequent must hold in the cycle after the antecedent.
`define PAL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("positional_array_list_core: next-cycle property violated");

`endif

// ===== rtl/core/pal_pkg.sv =====
// Shared types and constants of the positional array list.
// No dependencies; every other file but the assertion header imports it.
package pal_pkg;

    // Number of cells in the row; the count and found position widths are sized for it.
    localparam int DEPTH  = 64;

    localparam int CMD_W  = 2;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int CAP_W  = 7;
    localparam int STAT_W = 2;
    localparam int FPOS_W = 6;
    localparam int CNT_W  = 7;

    // The find scanner looks at this many cells per cycle.
    localparam int SCAN_WIN   = 8;
    localparam int SCAN_WIN_W = 3;
    localparam int BASE_W     = 8;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_POS   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_REMOVE = 2'd2;
    localparam logic [1:0] CELL_UPDATE = 2'd3;

    typedef struct packed {
        logic [1:0]       op;
        logic [POS_W-1:0] pos;
        logic [CNT_W-1:0] count;
        logic             match_load;
        logic             match_shift;
    } t_cell_ctl;

    typedef struct packed {
        logic              done;
        logic              hit;
        logic [FPOS_W-1:0] pos;
    } t_find_res;

endpackage

// ===== rtl/core/pal_cmd_if.sv =====
// Command channel of the positional array list.
// Depends on pal_pkg for the field widths.
interface pal_cmd_if import pal_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;

    modport source (output valid, command, position, value, input ready);
    modport sink   (input valid, command, position, value, output ready);
endinterface

// ===== rtl/core/pal_res_if.sv =====
// Result channel of the positional array list.
// Depends on pal_pkg for the field widths.
interface pal_res_if import pal_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [FPOS_W-1:0] found_position;
    logic [CNT_W-1:0]  entry_count;

    modport source (output valid, status, found_position, entry_count, input ready);
    modport sink   (input valid, status, found_position, entry_count, output ready);
endinterface

// ===== rtl/core/pal_cfg_if.sv =====
// Configuration write channel carrying the capacity register.
// Depends on pal_pkg for the register width.
interface pal_cfg_if import pal_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] capacity;

    modport source (output valid, capacity, input ready);
    modport sink   (input valid, capacity, output ready);
endinterface

// ===== rtl/core/pal_cell.sv =====
// One list cell: holds one entry and its find match bit.
// Depends on pal_pkg for the cell control struct and op codes.
module pal_cell import pal_pkg::*; #(
    parameter int IDX        = 0,
    parameter int ELEM_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_ctl             i_ctl,
    input  logic [ELEM_WIDTH-1:0] i_val,
    input  logic [ELEM_WIDTH-1:0] i_prev,
    input  logic [ELEM_WIDTH-1:0] i_next,
    input  logic                  i_match_hi,
    output logic [ELEM_WIDTH-1:0] o_data,
    output logic                  o_match
);

    logic [ELEM_WIDTH-1:0] r_data;
    logic                  r_match;
    logic                  w_above;
    logic                  w_at;
    logic                  w_live;

    assign w_above = 32'(IDX) > 32'(i_ctl.pos);
    assign w_at    = 32'(IDX) == 32'(i_ctl.pos);
    assign w_live  = 32'(IDX) < 32'(i_ctl.count);

    // Insert pulls from the lower neighbor, remove from the upper one.
    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            CELL_INSERT: begin
                if (w_above) begin
                    r_data <= i_prev;
                end else if (w_at) begin
                    r_data <= i_val;
                end
            end
            CELL_REMOVE: begin
                if (w_above || w_at) begin
                    r_data <= i_next;
                end
            end
            CELL_UPDATE: begin
                if (w_at) begin
                    r_data <= i_val;
                end
            end
            CELL_HOLD: begin
                r_data <= r_data;
            end
        endcase
    end

    // During a scan the match bits move down one window per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.match_load) begin
            r_match <= w_live && (r_data == i_val);
        end else if (i_ctl.match_shift) begin
            r_match <= i_match_hi;
        end
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

// ===== rtl/core/pal_find.sv =====
// Find scanner: walks the match bits of the cell row one window at a time.
// Depends on pal_pkg for widths and the scan result struct.
module pal_find import pal_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_run,
    input  logic [SCAN_WIN-1:0] i_win,
    input  logic [CNT_W-1:0]    i_count,
    output t_find_res           o_res
);

    logic [BASE_W-1:0]     r_base;
    logic [SCAN_WIN_W-1:0] w_enc;
    logic                  w_hit;
    logic                  w_last;
    logic [BASE_W:0]       w_next_base;

    always_comb begin
        w_enc = '0;
        for (int k = SCAN_WIN - 1; k >= 0; k--) begin
            if (i_win[k]) begin
                w_enc = SCAN_WIN_W'(k);
            end
        end
    end

    assign w_hit       = |i_win;
    assign w_next_base = {1'b0, r_base} + (BASE_W + 1)'(SCAN_WIN);
    // No match can lie at or beyond the entry count.
    assign w_last      = w_next_base >= (BASE_W + 1)'(i_count);

    assign o_res.done = w_hit || w_last;
    assign o_res.hit  = w_hit;
    assign o_res.pos  = w_hit ? FPOS_W'(r_base + BASE_W'(w_enc)) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_start) begin
            r_base <= '0;
        end else if (i_run && !o_res.done) begin
            r_base <= w_next_base[BASE_W-1:0];
        end
    end

endmodule

// ===== rtl/core/positional_array_list_core.sv =====
// Positional array list: a row of DEPTH cells holding an ordered list.
// Insert, remove, update: result in the cycle after the beat; one command per cycle
// while results are taken. Find: matches latch in all cells, then a scanner checks
// 8 cells per cycle until a hit or the list end; then result out and back to idle.
// Reset sets the count to 0 and capacity to 64; entries are not cleared.
`include "positional_array_list_core_assert.svh"

module positional_array_list_core import pal_pkg::*; #(
    parameter int ELEM_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pal_cmd_if.sink    i_cmd,
    pal_cfg_if.sink    i_cfg,
    pal_res_if.source  o_res
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic              r_state;
    logic              n_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [CAP_W-1:0]  r_capacity;
    logic              r_out_valid;
    logic [STAT_W-1:0] r_status;
    logic [STAT_W-1:0] n_status;
    logic [FPOS_W-1:0] r_fpos;
    logic [FPOS_W-1:0] n_fpos;
    logic              n_out_load;

    logic                  w_out_free;
    logic                  w_cmd_acc;
    logic                  w_ins_ok;
    logic                  w_in_range;
    logic                  w_full;
    logic [ELEM_WIDTH-1:0] w_key;
    t_cell_ctl             w_ctl;
    t_find_res             w_find;

    logic [ELEM_WIDTH-1:0] w_data [DEPTH];
    logic [DEPTH+SCAN_WIN-1:0] w_match_ext;

    assign w_out_free  = !r_out_valid || o_res.ready;
    assign i_cmd.ready = i_rst_n && (r_state == S_IDLE) && w_out_free;
    assign w_cmd_acc   = i_cmd.valid && i_cmd.ready;
    assign i_cfg.ready = i_rst_n;

    assign w_key = ELEM_WIDTH'({{ELEM_WIDTH{1'b0}}, i_cmd.value});

    assign w_in_range = i_cmd.position < r_count;
    assign w_full     = (r_count >= r_capacity) || (32'(r_count) >= 32'(DEPTH));
    assign w_ins_ok   = (i_cmd.position <= r_count) && !w_full;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_status   = STAT_OK;
        n_fpos     = '0;
        n_out_load = 1'b0;
        w_ctl.op          = CELL_HOLD;
        w_ctl.pos         = i_cmd.position;
        w_ctl.count       = r_count;
        w_ctl.match_load  = 1'b0;
        w_ctl.match_shift = 1'b0;
        if (r_state == S_SCAN) begin
            if (w_find.done) begin
                if (w_out_free) begin
                    n_out_load = 1'b1;
                    n_status   = w_find.hit ? STAT_OK : STAT_NOT_FOUND;
                    n_fpos     = w_find.pos;
                    n_state    = S_IDLE;
                end
            end else begin
                w_ctl.match_shift = 1'b1;
            end
        end else if (w_cmd_acc) begin
            unique case (i_cmd.command)
                CMD_INSERT: begin
                    n_out_load = 1'b1;
                    if (i_cmd.position > r_count) begin
                        n_status = STAT_BAD_POS;
                    end else if (w_full) begin
                        n_status = STAT_FULL;
                    end else begin
                        w_ctl.op = CELL_INSERT;
                        n_count  = CNT_W'(r_count + 7'd1);
                    end
                end
                CMD_REMOVE: begin
                    n_out_load = 1'b1;
                    if (!w_in_range) begin
                        n_status = STAT_BAD_POS;
                    end else begin
                        w_ctl.op = CELL_REMOVE;
                        n_count  = CNT_W'(r_count - 7'd1);
                    end
                end
                CMD_UPDATE: begin
                    n_out_load = 1'b1;
                    if (!w_in_range) begin
                        n_status = STAT_BAD_POS;
                    end else begin
                        w_ctl.op = CELL_UPDATE;
                    end
                end
                CMD_FIND: begin
                    w_ctl.match_load = 1'b1;
                    n_state          = S_SCAN;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_capacity  <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg.valid) begin
                r_capacity <= i_cfg.capacity;
            end
            if (n_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_out_load) begin
            r_status <= n_status;
            r_fpos   <= n_fpos;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.status         = r_status;
    assign o_res.found_position = r_fpos;
    assign o_res.entry_count    = r_count;

    assign w_match_ext[DEPTH+SCAN_WIN-1:DEPTH] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [ELEM_WIDTH-1:0] w_prev;
        logic [ELEM_WIDTH-1:0] w_next;

        if (g == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid_lo
            assign w_prev = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_next = w_data[g];
        end else begin : g_mid_hi
            assign w_next = w_data[g+1];
        end

        pal_cell #(
            .IDX        (g),
            .ELEM_WIDTH (ELEM_WIDTH)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_val      (w_key),
            .i_prev     (w_prev),
            .i_next     (w_next),
            .i_match_hi (w_match_ext[g+SCAN_WIN]),
            .o_data     (w_data[g]),
            .o_match    (w_match_ext[g])
        );
    end

    pal_find u_find (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ctl.match_load),
        .i_run   (r_state == S_SCAN),
        .i_win   (w_match_ext[SCAN_WIN-1:0]),
        .i_count (r_count),
        .o_res   (w_find)
    );

    `PAL_ASSERT_NOW(a_count_in_depth, i_clk, i_rst_n, 1'b1,
                    32'(r_count) <= 32'(DEPTH))
    `PAL_ASSERT_NEXT(a_find_scans, i_clk, i_rst_n,
                     w_cmd_acc && (i_cmd.command == CMD_FIND),
                     (r_state == S_SCAN) && (r_count == $past(r_count)))
    `PAL_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n,
                     w_cmd_acc && (i_cmd.command == CMD_INSERT) && w_ins_ok,
                     r_count == CNT_W'($past(r_count) + 7'd1))

endmodule

// ===== sim/positional_array_list_core_tb.sv =====
// Self-checking testbench for positional_array_list_core: directed and random list commands,
// predicted by an in-bench list model and compared field by field with every result beat.
// Depends on pal_pkg, the pal_cmd_if, pal_cfg_if and pal_res_if interfaces and the core RTL.
module positional_array_list_core_tb;
    import pal_pkg::*;

    localparam int LIST_DEPTH = 64;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [FPOS_W-1:0] found_pos;
        logic [CNT_W-1:0]  count;
    } list_outcome_t;

    logic clk;
    logic rst_n;

    pal_cmd_if cmd_ch ();
    pal_cfg_if cfg_ch ();
    pal_res_if res_ch ();

    positional_array_list_core DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    // Shadow copy of the list and the capacity register.
    logic [VAL_W-1:0] list_mem [LIST_DEPTH];
    int               list_len;
    logic [CAP_W-1:0] cap_shadow;
    logic [VAL_W-1:0] val_pool [8];

    list_outcome_t outcome_q [$];

    bit src_idle_en;
    bit sink_idle_en;
    int sink_hold;

    int fail_count;
    int results_seen;
    int items_sent;
    int cap_writes;
    int cmd_tally  [4];
    int stat_tally [4];

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int eff_capacity();
        return (cap_shadow > LIST_DEPTH) ? LIST_DEPTH : int'(cap_shadow);
    endfunction

    // Applies one command to the shadow list and returns the outcome the core must report.
    function automatic list_outcome_t apply_list_cmd(input logic [CMD_W-1:0] cmd,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic [VAL_W-1:0] val);
        list_outcome_t r;
        int            p;
        int            i;
        p           = int'(pos);
        r.status    = STAT_OK;
        r.found_pos = '0;
        case (cmd)
            CMD_INSERT: begin
                if (p > list_len) begin
                    r.status = STAT_BAD_POS;
                end else if (list_len >= eff_capacity()) begin
                    r.status = STAT_FULL;
                end else begin
                    for (i = list_len; i > p; i--) list_mem[i] = list_mem[i-1];
                    list_mem[p] = val;
                    list_len++;
                end
            end
            CMD_REMOVE: begin
                if (p >= list_len) begin
                    r.status = STAT_BAD_POS;
                end else begin
                    for (i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            CMD_UPDATE: begin
                if (p >= list_len) r.status = STAT_BAD_POS;
                else list_mem[p] = val;
            end
            default: begin
                r.status = STAT_NOT_FOUND;
                for (i = 0; i < list_len; i++) begin
                    if (list_mem[i] == val) begin
                        r.status    = STAT_OK;
                        r.found_pos = FPOS_W'(i);
                        break;
                    end
                end
            end
        endcase
        r.count = CNT_W'(list_len);
        cmd_tally[cmd]++;
        stat_tally[r.status]++;
        return r;
    endfunction

    function automatic void log_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endfunction

    // Sends one command beat and records its predicted outcome at the accepting edge.
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                            input logic [VAL_W-1:0] val);
        int gap;
        gap = src_idle_en ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.command  <= cmd;
        cmd_ch.position <= pos;
        cmd_ch.value    <= val;
        do @(posedge clk); while (cmd_ch.ready !== 1'b1);
        outcome_q.push_back(apply_list_cmd(cmd, pos, val));
        items_sent++;
    endtask

    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        drain_results();
        cfg_ch.valid    <= 1'b1;
        cfg_ch.capacity <= cap;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        cap_shadow = cap;
        cap_writes++;
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly in-range positions and values that repeat, so finds hit and shifts matter.
    task automatic send_random_cmd();
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        int               sel;
        sel = $urandom_range(0, 99);
        if (sel < 38) cmd = CMD_INSERT;
        else if (sel < 63) cmd = CMD_REMOVE;
        else if (sel < 78) cmd = CMD_UPDATE;
        else cmd = CMD_FIND;

        if ($urandom_range(0, 9) == 0) pos = POS_W'($urandom_range(0, 127));
        else if (cmd == CMD_INSERT) pos = POS_W'($urandom_range(0, list_len));
        else if (list_len > 0) pos = POS_W'($urandom_range(0, list_len - 1));
        else pos = POS_W'($urandom_range(0, 127));

        if (cmd == CMD_FIND && list_len > 0 && $urandom_range(0, 9) < 7)
            val = list_mem[$urandom_range(0, list_len - 1)];
        else if ($urandom_range(0, 1) == 1)
            val = val_pool[$urandom_range(0, 7)];
        else
            val = $urandom();
        send_cmd(cmd, pos, val);
    endtask

    task automatic test_empty_list();
        send_cmd(CMD_FIND, 7'd0, 32'h0);
        send_cmd(CMD_REMOVE, 7'd0, 32'h0);
        send_cmd(CMD_UPDATE, 7'd0, 32'h1111_1111);
        send_cmd(CMD_INSERT, 7'd1, 32'h2222_2222);
        send_cmd(CMD_INSERT, 7'd0, 32'hFFFF_FFFF);
        send_cmd(CMD_INSERT, 7'd0, 32'h0000_0000);
        send_cmd(CMD_INSERT, 7'd2, 32'hA5A5_5A5A);
        send_cmd(CMD_INSERT, 7'd127, 32'h3333_3333);
        send_cmd(CMD_INSERT, 7'd1, 32'h0000_0000);
        // Duplicate keys: the lowest position wins, and the position field is ignored.
        send_cmd(CMD_FIND, 7'd127, 32'h0000_0000);
        send_cmd(CMD_UPDATE, 7'd0, 32'h1234_5678);
        send_cmd(CMD_FIND, 7'd0, 32'h0000_0000);
        send_cmd(CMD_UPDATE, 7'd4, 32'h4444_4444);
        send_cmd(CMD_REMOVE, 7'd4, 32'h0);
        send_cmd(CMD_REMOVE, 7'd3, 32'h0);
        send_cmd(CMD_REMOVE, 7'd0, 32'h0);
        send_cmd(CMD_FIND, 7'd0, 32'hA5A5_5A5A);
        send_cmd(CMD_FIND, 7'd64, 32'hFFFF_FFFF);
    endtask

    task automatic test_capacity_limits();
        while (list_len > 0) send_cmd(CMD_REMOVE, 7'd0, 32'h0);
        write_capacity(7'd0);
        send_cmd(CMD_INSERT, 7'd0, 32'hDEAD_0001);
        send_cmd(CMD_INSERT, 7'd3, 32'hDEAD_0002);
        write_capacity(7'd2);
        send_cmd(CMD_INSERT, 7'd0, 32'hDEAD_0003);
        send_cmd(CMD_INSERT, 7'd1, 32'hDEAD_0004);
        send_cmd(CMD_INSERT, 7'd2, 32'hDEAD_0005);
        send_cmd(CMD_INSERT, 7'd5, 32'hDEAD_0006);
        // Lowering the capacity below the count keeps the entries but blocks inserts.
        write_capacity(7'd1);
        send_cmd(CMD_INSERT, 7'd0, 32'hDEAD_0007);
        send_cmd(CMD_REMOVE, 7'd0, 32'h0);
        send_cmd(CMD_INSERT, 7'd0, 32'hDEAD_0008);
        send_cmd(CMD_REMOVE, 7'd0, 32'h0);
        send_cmd(CMD_INSERT, 7'd0, 32'hDEAD_0009);
        send_cmd(CMD_FIND, 7'd0, 32'hDEAD_0009);
        write_capacity(7'd127);
    endtask

    task automatic test_fill_and_drain();
        int i;
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        while (list_len < LIST_DEPTH)
            send_cmd(CMD_INSERT, POS_W'($urandom_range(0, list_len)), $urandom());
        send_cmd(CMD_INSERT, 7'd64, 32'h5555_AAAA);
        send_cmd(CMD_INSERT, 7'd65, 32'h5555_AAAA);
        send_cmd(CMD_INSERT, 7'd127, 32'h5555_AAAA);
        send_cmd(CMD_UPDATE, 7'd63, 32'hCAFE_F00D);
        send_cmd(CMD_FIND, 7'd0, 32'hCAFE_F00D);
        for (i = 0; i < 6; i++)
            send_cmd(CMD_FIND, 7'd0, list_mem[$urandom_range(32, 63)]);
        send_cmd(CMD_FIND, 7'd0, ~list_mem[0]);
        while (list_len > 0)
            send_cmd(CMD_REMOVE, POS_W'($urandom_range(0, list_len - 1)), 32'h0);
        send_cmd(CMD_REMOVE, 7'd0, 32'h0);
    endtask

    // The sink holds off while commands keep coming, so the core backs up into its input.
    task automatic test_output_stall();
        int i;
        src_idle_en = 1'b0;
        sink_hold   = 80;
        for (i = 0; i < 40; i++) send_random_cmd();
        drain_results();
    endtask

    task automatic test_random_mix(input logic [CAP_W-1:0] cap, input int n,
                                   input bit src_idle, input bit sink_idle);
        int i;
        write_capacity(cap);
        src_idle_en  = src_idle;
        sink_idle_en = sink_idle;
        for (i = 0; i < n; i++) send_random_cmd();
    endtask

    initial begin : result_sink
        int stall;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (sink_hold > 0) begin
                stall     = sink_hold;
                sink_hold = 0;
            end else begin
                stall = sink_idle_en ? $urandom_range(0, 5) : 0;
            end
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (res_ch.valid !== 1'b1);
            check_result();
        end
    end

    task automatic check_result();
        list_outcome_t want;
        results_seen++;
        if (outcome_q.size() == 0) begin
            log_failure($sformatf("result beat with nothing pending: status %0d count %0d",
                                  res_ch.status, res_ch.entry_count));
            return;
        end
        want = outcome_q.pop_front();
        if (res_ch.status !== want.status || res_ch.found_position !== want.found_pos ||
            res_ch.entry_count !== want.count) begin
            log_failure($sformatf({"result %0d: status %0d/%0d found_position %0d/%0d ",
                                   "entry_count %0d/%0d (expected/actual)"},
                                  results_seen, want.status, res_ch.status, want.found_pos,
                                  res_ch.found_position, want.count, res_ch.entry_count));
        end
    endtask

    initial begin
        #3000000;
        $display("Timed out with %0d results pending.", outcome_q.size());
        $display("positional_array_list_core regression: fail");
        $finish;
    end

    initial begin
        int i;
        rst_n           <= 1'b0;
        cmd_ch.valid    <= 1'b0;
        cmd_ch.command  <= CMD_INSERT;
        cmd_ch.position <= '0;
        cmd_ch.value    <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.capacity <= CAP_RESET;
        list_len     = 0;
        cap_shadow   = CAP_RESET;
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        sink_hold    = 0;
        val_pool[0]  = 32'h0000_0000;
        val_pool[1]  = 32'hFFFF_FFFF;
        for (i = 2; i < 8; i++) val_pool[i] = $urandom();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_capacity_limits();
        test_fill_and_drain();
        test_output_stall();
        test_random_mix(7'd64, 120, 1'b1, 1'b1);
        test_random_mix(7'd5, 70, 1'b0, 1'b0);
        test_random_mix(CAP_W'($urandom_range(1, 63)), 90, 1'b1, 1'b0);
        test_random_mix(7'd1, 40, 1'b0, 1'b1);
        test_random_mix(7'd127, 100, 1'b1, 1'b1);

        drain_results();
        repeat (20) @(posedge clk);
        $display("Covered %0d commands (%0d insert, %0d remove, %0d update, %0d find), %0d %s",
                 items_sent, cmd_tally[CMD_INSERT], cmd_tally[CMD_REMOVE],
                 cmd_tally[CMD_UPDATE], cmd_tally[CMD_FIND], results_seen, "results checked.");
        $display("Outcomes: %0d ok, %0d bad position, %0d full, %0d not found; %0d %s %0d.",
                 stat_tally[STAT_OK], stat_tally[STAT_BAD_POS], stat_tally[STAT_FULL],
                 stat_tally[STAT_NOT_FOUND], cap_writes, "capacity writes, mismatches",
                 fail_count);
        if (fail_count == 0)
            $display("positional_array_list_core regression: pass");
        else
            $display("positional_array_list_core regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/pal_pkg.sv
rtl/core/pal_cmd_if.sv
rtl/core/pal_res_if.sv
rtl/core/pal_cfg_if.sv
rtl/core/pal_cell.sv
rtl/core/pal_find.sv
rtl/core/positional_array_list_core.sv
sim/positional_array_list_core_tb.sv
